// ===== design/sidta_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Shared constants, state and cell-operation types, digit-count function.
// No dependencies.
package sidta_pkg;

  // Default input width
  localparam int unsigned ValueBitsDef = 32;

  // ASCII codes
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // Double-dabble correction: a digit above four gets three added before the shift
  localparam logic [3:0] DabbleLimit = 4'd4;
  localparam logic [3:0] DabbleAdd   = 4'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Operation applied to every BCD cell in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_DSHIFT
  } cell_op_e;

  // Decimal digits of 2^(bits-1), the largest magnitude at that width
  function automatic int unsigned dec_digits(input int unsigned bits);
    logic [63:0] v;
    int unsigned n;
    v = 64'd1 << (bits - 1);
    n = 0;
    for (int i = 0; i < 24; i++) begin
      if (v != 64'd0) begin
        v = v / 64'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== design/sidta_cell.sv =====
// One BCD digit cell of the converter chain.
// Shifts a bit in (double-dabble), takes its neighbor's digit, clears or holds.
// Depends on sidta_pkg.
module sidta_cell (
  input  logic                clk_i,
  input  sidta_pkg::cell_op_e op_i,
  input  logic                bit_i,
  input  logic [3:0]          digit_i,
  output logic                carry_o,
  output logic [3:0]          digit_o
);
  import sidta_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add-3 correction before the shift
  assign adj     = (digit_q > DabbleLimit) ? digit_q + DabbleAdd : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  // Next digit
  always_comb begin
    unique case (op_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_CLEAR:  digit_d = 4'd0;
      CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      CELL_DSHIFT: digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// Signed integer to decimal ASCII converter, top level: control and cell chain.
// Depends on sidta_pkg and sidta_cell.
//
// Takes one signed two's complement integer per input beat and emits its decimal
// text one character per output beat, most significant first, with a leading
// minus for negative values and last_o set on the final digit. Leading zeros are
// dropped; zero gives "0"; the most negative value converts exactly. A row of
// BCD digit cells converts the magnitude by shift-and-add-3, one input bit per
// cycle, once the cells are cleared at acceptance. The same cells then shift
// digits toward the output end one per cycle: first each suppressed leading
// zero is discarded, then, after the minus sign if any, each digit is shifted
// out as its character is loaded while the output side takes beats; an output
// stall holds the shift. One item is handled at a time; the next is accepted
// once the final character is loaded into the output register.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = sidta_pkg::ValueBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   character_o,
  output logic                         last_o
);
  import sidta_pkg::*;

  localparam int unsigned NumDigits = dec_digits(VALUE_BITS);
  localparam int unsigned CntW      = $clog2(VALUE_BITS + 1);
  localparam int unsigned RemW      = $clog2(NumDigits + 1);

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_in;
  logic                  neg_q;
  logic [CntW-1:0]       bit_cnt_q;
  logic [RemW-1:0]       rem_q;
  logic                  out_valid_q;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic                  out_load;
  logic                  in_accept;
  logic                  out_free;
  logic                  skip_zero;
  cell_op_e              cell_op;
  logic [3:0]            digit [NumDigits];
  logic [NumDigits-1:0]  carry;
  logic [NumDigits-1:0]  cell_bit;
  logic [3:0]            top_digit;

  // Handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Unsigned magnitude of the input
  assign mag_in = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;

  assign top_digit = digit[NumDigits-1];
  assign skip_zero = (top_digit == 4'd0) && (rem_q > RemW'(1));

  // Cell chain: bits and digits move from cell 0 toward the top cell
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_bit[i] = mag_q[VALUE_BITS-1];
      sidta_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (cell_op),
        .bit_i   (cell_bit[i]),
        .digit_i (4'd0),
        .carry_o (carry[i]),
        .digit_o (digit[i])
      );
    end else begin : g_rest
      assign cell_bit[i] = carry[i-1];
      sidta_cell u_cell (
        .clk_i   (clk_i),
        .op_i    (cell_op),
        .bit_i   (cell_bit[i]),
        .digit_i (digit[i-1]),
        .carry_o (carry[i]),
        .digit_o (digit[i])
      );
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_CONV;
      ST_CONV: if (bit_cnt_q == CntW'(1)) state_d = ST_SKIP;
      ST_SKIP: begin
        if (!skip_zero) state_d = neg_q ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: if (out_free) state_d = ST_EMIT;
      ST_EMIT: if (out_free && rem_q == RemW'(1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    cell_op  = CELL_HOLD;
    out_load = 1'b0;
    char_d   = CharZero + {4'd0, top_digit};
    last_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_accept) cell_op = CELL_CLEAR;
      ST_CONV: cell_op = CELL_DABBLE;
      ST_SKIP: if (skip_zero) cell_op = CELL_DSHIFT;
      ST_SIGN: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = CharMinus;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          last_d   = (rem_q == RemW'(1));
          cell_op  = CELL_DSHIFT;
        end
      end
      default: cell_op = CELL_HOLD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        bit_cnt_q <= CntW'(VALUE_BITS);
      end else if (state_q == ST_CONV) begin
        bit_cnt_q <= bit_cnt_q - CntW'(1);
      end
      if (in_accept) begin
        rem_q <= RemW'(NumDigits);
      end else if (cell_op == CELL_DSHIFT) begin
        rem_q <= rem_q - RemW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q <= mag_in;
      neg_q <= value_i[VALUE_BITS-1];
    end else if (state_q == ST_CONV) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
    end
    if (out_load) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

endmodule
